/* hw/rtl/sine_plasma_pixel_generator_assert.svh */
// ----------------------------------------------------------------------------
// Sine plasma pixel generator assertion macros
// Shared concurrent property wrappers for the pipeline checks.
// ----------------------------------------------------------------------------
`ifndef SINE_PLASMA_PIXEL_GENERATOR_ASSERT_SVH
`define SINE_PLASMA_PIXEL_GENERATOR_ASSERT_SVH

// same-cycle implication
`define SPPG_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sppg: same-cycle check failed");

// next-cycle implication
`define SPPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sppg: next-cycle check failed");

`endif

/* hw/rtl/sppg_pkg.sv */
// ----------------------------------------------------------------------------
// Sine plasma pixel generator package
// Widths, configuration types, register indexes and the two constant ROMs.
// ----------------------------------------------------------------------------
`default_nettype none

package sppg_pkg;

   localparam int TEXTURE_WIDTH   = 320;
   localparam int SINE_ENTRIES    = 512;
   localparam int PALETTE_ENTRIES = 256;

   localparam int SINE_ADDR_WIDTH = $clog2(SINE_ENTRIES);
   localparam int PAL_ADDR_WIDTH  = $clog2(PALETTE_ENTRIES);

   localparam int COLUMN_WIDTH = 9;
   localparam int ROW_WIDTH    = 8;
   localparam int FRAME_WIDTH  = 9;
   localparam int PIXEL_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 9;
   localparam int DIST_WIDTH   = 10;
   localparam int SQ_WIDTH     = 2 * DIST_WIDTH;

   localparam logic [63:0] ONE_Q30 = 64'd1073741824;
   localparam logic [63:0] PI_Q32  = 64'd13493037705;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_BAND_RADIUS,
      CSR_PERSPECTIVE_SHIFT,
      CSR_VERTICAL_SPEED,
      CSR_HORIZONTAL_SPEED,
      CSR_SWAY_SPEED,
      CSR_CENTER_COLUMN
   } csr_index_type;

   typedef struct packed {
      logic [8:0] band_radius;
      logic [3:0] perspective_shift;
      logic [8:0] vertical_speed;
      logic [8:0] horizontal_speed;
      logic [8:0] sway_speed;
      logic [8:0] center_column;
   } cfg_type;

   // front half to back half
   typedef struct packed {
      logic [SINE_ADDR_WIDTH-1:0] x_addr;
      logic [DIST_WIDTH-1:0]      distance;
      logic signed [7:0]          ripple_y;
   } front_beat_type;

   typedef logic [SINE_ENTRIES-1:0][7:0]                sine_rom_type;
   typedef logic [PALETTE_ENTRIES-1:0][PIXEL_WIDTH-1:0] palette_rom_type;

   // Taylor term divisors, sine and cosine series
   function automatic logic [63:0] series_div(input logic [63:0] v, input int n,
                                              input logic use_cos);
      logic [63:0] res;
      case (n)
         1: res = use_cos ? v / 2   : v / 6;
         2: res = use_cos ? v / 12  : v / 20;
         3: res = use_cos ? v / 30  : v / 42;
         4: res = use_cos ? v / 56  : v / 72;
         5: res = use_cos ? v / 90  : v / 110;
         6: res = use_cos ? v / 132 : v / 156;
         7: res = use_cos ? v / 182 : v / 210;
         8: res = use_cos ? v / 240 : v / 272;
         default: res = '0;
      endcase
      return res;
   endfunction

   // sin(q*pi/256) in Q30, q in 0..128
   function automatic logic [63:0] quarter_wave(input logic [63:0] q);
      logic        use_cos;
      logic [63:0] a;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      use_cos = (q > 64'd64);
      a    = use_cos ? (64'd128 - q) : q;
      x    = (a * PI_Q32) >> 10;
      x2   = (x * x) >> 30;
      term = use_cos ? ONE_Q30 : x;
      pos  = term;
      neg  = '0;
      for (int n = 1; n <= 8; n++) begin
         term = series_div((term * x2) >> 30, n, use_cos);
         if ((n & 1) != 0) neg = neg + term;
         else pos = pos + term;
      end
      return (pos > neg) ? (pos - neg) : 64'd0;
   endfunction

   function automatic logic [63:0] abs_wave(input logic [63:0] k);
      logic [63:0] h;
      h = k & 64'd255;
      return quarter_wave((h > 64'd128) ? (64'd256 - h) : h);
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] r;
      logic [63:0] bit_w;
      rem   = v;
      r     = '0;
      bit_w = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (rem >= r + bit_w) begin
            rem = rem - (r + bit_w);
            r   = (r >> 1) + bit_w;
         end else begin
            r = r >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return r;
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0]  m;
      for (int k = 0; k < SINE_ENTRIES; k++) begin
         m = (64'd127 * abs_wave(64'(k))) >> 30;
         rom[k] = ((k & 256) != 0) ? (8'd0 - m[7:0]) : m[7:0];
      end
      return rom;
   endfunction

   function automatic palette_rom_type build_palette_rom();
      palette_rom_type rom;
      logic [63:0]     s;
      logic [63:0]     in_v;
      logic [63:0]     r;
      logic [63:0]     g;
      logic [63:0]     b;
      for (int k = 0; k < PALETTE_ENTRIES; k++) begin
         s    = abs_wave(64'((2 * k) & (SINE_ENTRIES - 1)));
         in_v = isqrt64(s << 30);
         if (in_v < (ONE_Q30 >> 1)) begin
            r = '0;
            g = (64'd200 * in_v) >> 30;
            b = (64'd400 * in_v) >> 30;
         end else if (in_v * 64'd10 < 64'd9 * ONE_Q30) begin
            r = 64'd100 + ((64'd775 * (in_v - (ONE_Q30 >> 1))) >> 31);
            g = r;
            b = 64'd255;
         end else begin
            r = 64'd255;
            g = 64'd255;
            b = 64'd255;
         end
         rom[k] = {r[7:3], g[7:2], b[7:3]};
      end
      return rom;
   endfunction

   localparam sine_rom_type    SINE_ROM    = build_sine_rom();
   localparam palette_rom_type PALETTE_ROM = build_palette_rom();

endpackage

`default_nettype wire

/* hw/rtl/sppg_if.sv */
// ----------------------------------------------------------------------------
// Sine plasma pixel generator channels
// Valid/ready interfaces for coordinate requests and pixel responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface sppg_req_if;
   logic                               valid;
   logic                               ready;
   logic [sppg_pkg::COLUMN_WIDTH-1:0]  column;
   logic [sppg_pkg::ROW_WIDTH-1:0]     row;
   logic [sppg_pkg::FRAME_WIDTH-1:0]   frame;

   modport source (output valid, column, row, frame, input ready);
   modport sink   (input valid, column, row, frame, output ready);
endinterface

interface sppg_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [sppg_pkg::PIXEL_WIDTH-1:0]   pixel_color;

   modport source (output valid, pixel_color, input ready);
   modport sink   (input valid, pixel_color, output ready);
endinterface

`default_nettype wire

/* hw/rtl/sppg_csr.sv */
// ----------------------------------------------------------------------------
// Sine plasma configuration registers
// Write-only register file decoded from the csr write port.
// ----------------------------------------------------------------------------
`default_nettype none

module sppg_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write_enable,
   input  wire logic [sppg_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [sppg_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   output sppg_pkg::cfg_type                         cfg
);
   import sppg_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_BAND_RADIUS:       cfg_in.band_radius       = csr_write_data[8:0];
            CSR_PERSPECTIVE_SHIFT: cfg_in.perspective_shift = csr_write_data[3:0];
            CSR_VERTICAL_SPEED:    cfg_in.vertical_speed    = csr_write_data[8:0];
            CSR_HORIZONTAL_SPEED:  cfg_in.horizontal_speed  = csr_write_data[8:0];
            CSR_SWAY_SPEED:        cfg_in.sway_speed        = csr_write_data[8:0];
            CSR_CENTER_COLUMN:     cfg_in.center_column     = csr_write_data[8:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.band_radius       <= 9'd80;
         cfg_ff.perspective_shift <= 4'd6;
         cfg_ff.vertical_speed    <= 9'd3;
         cfg_ff.horizontal_speed  <= 9'd5;
         cfg_ff.sway_speed        <= 9'd2;
         cfg_ff.center_column     <= 9'(TEXTURE_WIDTH / 2);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* hw/rtl/sppg_front.sv */
// ----------------------------------------------------------------------------
// Sine plasma front stages
// Phase products, sway and vertical ripple lookup, band column and distance.
// ----------------------------------------------------------------------------
`default_nettype none

module sppg_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  sppg_pkg::cfg_type          cfg,
   sppg_req_if.sink                   req,
   output logic                       down_valid,
   input  wire logic                  down_ready,
   output sppg_pkg::front_beat_type   down_beat
);
   import sppg_pkg::*;

   // stage 1: sine addresses
   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   logic                       s1_ready;
   logic [COLUMN_WIDTH-1:0]    s1_column_ff;
   logic [SINE_ADDR_WIDTH-1:0] s1_sway_addr_ff;
   logic [SINE_ADDR_WIDTH-1:0] s1_ry_addr_ff;
   logic [SINE_ADDR_WIDTH-1:0] s1_fh_ff;
   logic [SINE_ADDR_WIDTH-1:0] s1_sway_addr_in;
   logic [SINE_ADDR_WIDTH-1:0] s1_ry_addr_in;
   logic [SINE_ADDR_WIDTH-1:0] s1_fh_in;
   logic [17:0]                prod_sway;
   logic [17:0]                prod_vert;
   logic [17:0]                prod_horz;

   // stage 2: sine values
   logic                       s2_valid_ff;
   logic                       s2_valid_in;
   logic                       s2_ready;
   logic [COLUMN_WIDTH-1:0]    s2_column_ff;
   logic signed [7:0]          s2_sway_ff;
   logic signed [7:0]          s2_ry_ff;
   logic [SINE_ADDR_WIDTH-1:0] s2_fh_ff;

   // stage 3: band geometry
   logic                       s3_valid_ff;
   logic                       s3_valid_in;
   logic                       s3_ready;
   front_beat_type             s3_beat_ff;
   front_beat_type             s3_beat_in;
   logic signed [7:0]          sway;
   logic [10:0]                rx;
   logic [10:0]                diff;
   logic [10:0]                dist_wide;

   assign s3_ready = !s3_valid_ff || down_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign req.ready = s1_ready;

   always_comb begin
      prod_sway = req.frame * cfg.sway_speed;
      prod_vert = req.frame * cfg.vertical_speed;
      prod_horz = req.frame * cfg.horizontal_speed;
      s1_sway_addr_in = {1'b0, req.row} + prod_sway[SINE_ADDR_WIDTH-1:0];
      s1_ry_addr_in   = {req.row[6:0], 2'b00} + prod_vert[SINE_ADDR_WIDTH-1:0];
      s1_fh_in        = prod_horz[SINE_ADDR_WIDTH-1:0];
   end

   always_comb begin
      // arithmetic shift floors toward minus infinity
      sway       = s2_sway_ff >>> 1;
      rx         = {2'b00, s2_column_ff} + {{3{sway[7]}}, sway};
      diff       = rx - {2'b00, cfg.center_column};
      dist_wide  = diff[10] ? (~diff + 11'd1) : diff;
      s3_beat_in.x_addr   = {rx[7:0], 1'b0} + s2_fh_ff;
      s3_beat_in.distance = dist_wide[DIST_WIDTH-1:0];
      s3_beat_in.ripple_y = s2_ry_ff;
   end

   assign s1_valid_in = s1_ready ? req.valid   : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_column_ff    <= req.column;
         s1_sway_addr_ff <= s1_sway_addr_in;
         s1_ry_addr_ff   <= s1_ry_addr_in;
         s1_fh_ff        <= s1_fh_in;
      end
      if (s2_ready) begin
         s2_column_ff <= s1_column_ff;
         s2_sway_ff   <= $signed(SINE_ROM[s1_sway_addr_ff]);
         s2_ry_ff     <= $signed(SINE_ROM[s1_ry_addr_ff]);
         s2_fh_ff     <= s1_fh_ff;
      end
      if (s3_ready) begin
         s3_beat_ff <= s3_beat_in;
      end
   end

   assign down_valid = s3_valid_ff;
   assign down_beat  = s3_beat_ff;

endmodule

`default_nettype wire

/* hw/rtl/sppg_back.sv */
// ----------------------------------------------------------------------------
// Sine plasma back stages
// Horizontal ripple lookup, distance square, palette index and color.
// ----------------------------------------------------------------------------
`default_nettype none

module sppg_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  sppg_pkg::cfg_type          cfg,
   input  wire logic                  up_valid,
   output logic                       up_ready,
   input  sppg_pkg::front_beat_type   up_beat,
   sppg_rsp_if.source                 rsp
);
   import sppg_pkg::*;

   `include "sine_plasma_pixel_generator_assert.svh"

   // stage 4: ripple and square
   logic                      s4_valid_ff;
   logic                      s4_valid_in;
   logic                      s4_ready;
   logic signed [7:0]         s4_rx_ff;
   logic signed [7:0]         s4_ry_ff;
   logic [SQ_WIDTH-1:0]       s4_sq_ff;
   logic                      s4_black_ff;

   // stage 5: palette index
   logic                      s5_valid_ff;
   logic                      s5_valid_in;
   logic                      s5_ready;
   logic [PAL_ADDR_WIDTH-1:0] s5_idx_ff;
   logic [PAL_ADDR_WIDTH-1:0] s5_idx_in;
   logic                      s5_black_ff;
   logic [SQ_WIDTH-1:0]       sq_shifted;

   // stage 6: output color
   logic                      s6_valid_ff;
   logic                      s6_valid_in;
   logic                      s6_ready;
   logic [PIXEL_WIDTH-1:0]    s6_pixel_ff;
   logic [PIXEL_WIDTH-1:0]    s6_pixel_in;

   assign s6_ready = !s6_valid_ff || rsp.ready;
   assign s5_ready = !s5_valid_ff || s6_ready;
   assign s4_ready = !s4_valid_ff || s5_ready;
   assign up_ready = s4_ready;

   always_comb begin
      sq_shifted = s4_sq_ff >> cfg.perspective_shift;
      // index wraps mod palette size, so only the low bits matter
      s5_idx_in  = s4_ry_ff[7:0] + s4_rx_ff[7:0] + sq_shifted[PAL_ADDR_WIDTH-1:0];
      s6_pixel_in = s5_black_ff ? '0 : PALETTE_ROM[s5_idx_ff];
   end

   assign s4_valid_in = s4_ready ? up_valid    : s4_valid_ff;
   assign s5_valid_in = s5_ready ? s4_valid_ff : s5_valid_ff;
   assign s6_valid_in = s6_ready ? s5_valid_ff : s6_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s4_valid_in;
         s5_valid_ff <= s5_valid_in;
         s6_valid_ff <= s6_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready) begin
         s4_rx_ff    <= $signed(SINE_ROM[up_beat.x_addr]);
         s4_ry_ff    <= up_beat.ripple_y;
         s4_sq_ff    <= up_beat.distance * up_beat.distance;
         s4_black_ff <= up_beat.distance > {1'b0, cfg.band_radius};
      end
      if (s5_ready) begin
         s5_idx_ff   <= s5_idx_in;
         s5_black_ff <= s4_black_ff;
      end
      if (s6_ready) begin
         s6_pixel_ff <= s6_pixel_in;
      end
   end

   assign rsp.valid       = s6_valid_ff;
   assign rsp.pixel_color = s6_pixel_ff;

   `SPPG_ASSERT_NEXT(a_black_beat_is_zero, clock, reset, s5_valid_ff && s5_black_ff && s6_ready, s6_pixel_ff == '0)
   `SPPG_ASSERT_NEXT(a_index_holds_on_stall, clock, reset, s5_valid_ff && !s6_ready, s5_valid_ff && $stable(s5_idx_ff))
   `SPPG_ASSERT_IMPLY(a_backpressure_only_when_full, clock, reset, !up_ready, s4_valid_ff && s5_valid_ff && s6_valid_ff)

endmodule

`default_nettype wire

/* hw/rtl/sine_plasma_pixel_generator.sv */
// ----------------------------------------------------------------------------
// Sine plasma pixel generator
// Swaying, rippling metal band rendered as one RGB565 pixel per coordinate.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries column, row and frame (frame count mod 512); a beat moves
//   when valid and ready are both high. rsp_if returns one pixel_color beat
//   for every request beat, in order.
//   csr_* writes the six band registers; write them only while no request
//   is in flight.
// Pipeline: six register stages; a result appears on rsp_if from the last
//   stage register and can be taken on the next edge.
// Throughput: one pixel per clock while rsp_if is ready, set by the six-stage
//   pipeline with a constant sine ROM read in stages two and four and a
//   palette ROM read in stage six.
// Reset: synchronous; clears all stage valid bits and loads the default
//   register values (radius 80, shift 6, speeds 3/5/2, center 160).
// Stall: each stage holds while the one after it is full and not taking; a
//   stage that is empty still loads, so bubbles close up while rsp_if waits.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_plasma_pixel_generator (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   sppg_req_if.sink                                  req_if,
   sppg_rsp_if.source                                rsp_if,
   input  wire logic                                 csr_write_enable,
   input  wire logic [sppg_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [sppg_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import sppg_pkg::*;

   cfg_type        cfg;
   logic           link_valid;
   logic           link_ready;
   front_beat_type link_beat;

   sppg_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   sppg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req        (req_if),
      .down_valid (link_valid),
      .down_ready (link_ready),
      .down_beat  (link_beat)
   );

   sppg_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .up_valid (link_valid),
      .up_ready (link_ready),
      .up_beat  (link_beat),
      .rsp      (rsp_if)
   );

endmodule

`default_nettype wire
